// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/plq_pkg.sv =====
// package with sizes, codes and word types of the price level order queue table
package plq_pkg;

  localparam int NUM_LEVELS       = 64;
  localparam int ORDERS_PER_LEVEL = 16;
  localparam int PRICE_BITS       = 16;
  localparam int ORDER_BITS       = 32;

  localparam int LVL_W   = $clog2(NUM_LEVELS);
  localparam int HEAD_W  = (ORDERS_PER_LEVEL > 1) ? $clog2(ORDERS_PER_LEVEL) : 1;
  localparam int CNT_W   = $clog2(ORDERS_PER_LEVEL + 1);
  localparam int OADDR_W = $clog2(NUM_LEVELS * ORDERS_PER_LEVEL);

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_POP    = 2'd2;
  localparam logic [1:0] REQ_SEARCH = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_MISS       = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [1:0] ST_QUEUE_FULL = 2'd3;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [PRICE_BITS-1:0] price;
    logic [ORDER_BITS-1:0] order_data;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic                  found;
    logic [ORDER_BITS-1:0] order_out;
    logic [CNT_W-1:0]      queued_count;
  } rsp_t;

  typedef struct packed {
    logic [PRICE_BITS-1:0] price;
    logic [HEAD_W-1:0]     head;
    logic [CNT_W-1:0]      count;
  } level_t;

endpackage

// ===== rtl/price_level_order_queue_table.sv =====
// price level order queue table: top level with scan sequencer and level/order memories
//
// Request channel (req_valid, req_stall, req) carries one word per request:
// insert, remove level, pop oldest order or search level, keyed by price.
// Response channel (rsp_valid, rsp_stall, rsp) returns exactly one word per
// request with status, found flag, popped order and orders left at the level.
// A request is taken only while the block is idle; req_stall stays high while
// it works. The lookup walks the level memory one slot per cycle through a
// single price comparator, stopping at the first valid match, and notes the
// lowest free slot on the way. A hit ends the scan at its matching slot and a
// miss ends it after the last slot; a pop then adds a step that reads the order
// memory. The block works on one request at a time, and the scan sets how
// fast requests go through. The next request can be taken in the cycle after
// a response word is issued.
// A finished word sits in the response register while the next request is
// taken; if rsp_stall holds it, the following result waits in the sequencer.
// Reset clears the level valid bits, so the table starts empty, and drops any
// pending response. Level and order memories need no clearing pass.
module price_level_order_queue_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  plq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output plq_pkg::rsp_t rsp
);
  import plq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]            state;
  req_t                  cur;
  logic [NUM_LEVELS-1:0] level_valid;

  level_t                level_mem [NUM_LEVELS];
  level_t                level_rd;
  level_t                ent;
  logic [ORDER_BITS-1:0] order_mem [NUM_LEVELS*ORDERS_PER_LEVEL];
  logic [ORDER_BITS-1:0] order_rd;

  logic [LVL_W:0]        scan_idx;
  logic [LVL_W-1:0]      raddr;
  logic [LVL_W-1:0]      rd_idx;
  logic                  rd_pend;
  logic                  issue;
  logic                  match;
  logic                  last;

  logic                  hit;
  logic [LVL_W-1:0]      hit_idx;
  logic                  free_found;
  logic [LVL_W-1:0]      free_idx;

  logic                  full;
  logic [CNT_W:0]        tail_sum;
  logic [HEAD_W-1:0]     tail;
  logic [HEAD_W:0]       head_sum;
  logic [HEAD_W-1:0]     head_nx;
  logic                  pop_ok;

  logic                  lm_we;
  logic [LVL_W-1:0]      lm_waddr;
  level_t                lm_wdata;
  logic                  om_we;
  logic [OADDR_W-1:0]    om_waddr;
  logic [OADDR_W-1:0]    om_raddr;
  logic                  set_valid;
  logic                  clr_valid;
  rsp_t                  res;
  rsp_t                  res_next;

  function automatic logic [OADDR_W-1:0] oaddr(input logic [LVL_W-1:0] lvl,
                                               input logic [HEAD_W-1:0] slot);
    oaddr = OADDR_W'(OADDR_W'(lvl) * OADDR_W'(ORDERS_PER_LEVEL) + OADDR_W'(slot));
  endfunction

  assign req_stall = (state != S_IDLE);

  // scan address and compare
  assign raddr = scan_idx[LVL_W-1:0];
  assign issue = (state == S_SCAN) && (scan_idx < (LVL_W+1)'(NUM_LEVELS));
  assign match = rd_pend && level_valid[rd_idx] && (level_rd.price == cur.price);
  assign last  = rd_pend && (rd_idx == LVL_W'(NUM_LEVELS - 1));

  // fifo pointer arithmetic
  assign full     = (ent.count >= CNT_W'(ORDERS_PER_LEVEL));
  assign tail_sum = (CNT_W+1)'(ent.head) + (CNT_W+1)'(ent.count);
  assign tail     = (tail_sum >= (CNT_W+1)'(ORDERS_PER_LEVEL)) ?
                    HEAD_W'(tail_sum - (CNT_W+1)'(ORDERS_PER_LEVEL)) : HEAD_W'(tail_sum);
  assign head_sum = (HEAD_W+1)'(ent.head) + (HEAD_W+1)'(1);
  assign head_nx  = (head_sum >= (HEAD_W+1)'(ORDERS_PER_LEVEL)) ?
                    '0 : head_sum[HEAD_W-1:0];
  assign pop_ok   = hit && (ent.count != '0);
  assign om_raddr = oaddr(hit_idx, ent.head);

  always_comb begin
    lm_we     = 1'b0;
    lm_waddr  = hit_idx;
    lm_wdata  = ent;
    om_we     = 1'b0;
    om_waddr  = oaddr(hit_idx, tail);
    set_valid = 1'b0;
    clr_valid = 1'b0;
    res_next.status       = ST_OK;
    res_next.found        = hit;
    res_next.order_out    = '0;
    res_next.queued_count = '0;
    if (state == S_EXEC) begin
      case (cur.req_type)
        REQ_INSERT: begin
          if (hit) begin
            if (full) begin
              res_next.status       = ST_QUEUE_FULL;
              res_next.queued_count = ent.count;
            end else begin
              om_we                 = 1'b1;
              lm_we                 = 1'b1;
              lm_wdata.count        = ent.count + CNT_W'(1);
              res_next.queued_count = ent.count + CNT_W'(1);
            end
          end else if (!free_found) begin
            res_next.status = ST_TABLE_FULL;
          end else begin
            set_valid             = 1'b1;
            lm_we                 = 1'b1;
            lm_waddr              = free_idx;
            lm_wdata.price        = cur.price;
            lm_wdata.head         = '0;
            lm_wdata.count        = CNT_W'(1);
            om_we                 = 1'b1;
            om_waddr              = oaddr(free_idx, '0);
            res_next.queued_count = CNT_W'(1);
          end
        end
        REQ_REMOVE: begin
          if (hit) begin
            clr_valid = 1'b1;
          end else begin
            res_next.status = ST_MISS;
          end
        end
        REQ_POP: begin
          if (pop_ok) begin
            lm_we                 = 1'b1;
            lm_wdata.head         = head_nx;
            lm_wdata.count        = ent.count - CNT_W'(1);
            res_next.queued_count = ent.count - CNT_W'(1);
          end else begin
            res_next.status = ST_MISS;
          end
        end
        default: begin
          if (hit) begin
            res_next.queued_count = ent.count;
          end else begin
            res_next.status = ST_MISS;
          end
        end
      endcase
    end
  end

  // level memory
  always_ff @(posedge clk) begin
    if (lm_we) begin
      level_mem[lm_waddr] <= lm_wdata;
    end
    level_rd <= level_mem[raddr];
  end

  // order memory
  always_ff @(posedge clk) begin
    if (om_we) begin
      order_mem[om_waddr] <= cur.order_data;
    end
    order_rd <= order_mem[om_raddr];
  end

  // level valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      level_valid <= '0;
    end else begin
      if (set_valid) begin
        level_valid[free_idx] <= 1'b1;
      end
      if (clr_valid) begin
        level_valid[hit_idx] <= 1'b0;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      if (state == S_OUT && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur        <= req;
            scan_idx   <= '0;
            rd_pend    <= 1'b0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_pend <= issue;
          rd_idx  <= raddr;
          if (issue) begin
            scan_idx <= scan_idx + (LVL_W+1)'(1);
            if (!level_valid[raddr] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= raddr;
            end
          end
          if (match) begin
            hit     <= 1'b1;
            hit_idx <= rd_idx;
            ent     <= level_rd;
            state   <= S_EXEC;
          end else if (last) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res <= res_next;
          if (cur.req_type == REQ_POP && pop_ok) begin
            state <= S_POP;
          end else begin
            state <= S_OUT;
          end
        end
        S_POP: begin
          res.order_out <= order_rd;
          state         <= S_OUT;
        end
        S_OUT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/plq_checker.sv =====
// port checker for the price level order queue table and its bind
`include "assert_macros.svh"

module plq_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input plq_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input plq_pkg::rsp_t rsp
);
  import plq_pkg::*;

  logic req_acc;

  assign req_acc  = req_valid && !req_stall;

  // a taken request keeps the block busy in the next cycle
  `ASSERT_NXT(a_busy_after_accept, clk, rst, req_acc, req_stall)

  // only a successful response can carry an order word
  `ASSERT_IMP(a_order_only_ok, clk, rst, rsp_valid && (rsp.status != ST_OK),
              rsp.order_out == '0)

  // refused insert into a full table has no level
  `ASSERT_IMP(a_table_full_word, clk, rst, rsp_valid && (rsp.status == ST_TABLE_FULL),
              !rsp.found && (rsp.queued_count == '0))

  // a full queue implies the level exists and is at capacity
  `ASSERT_IMP(a_queue_full_word, clk, rst, rsp_valid && (rsp.status == ST_QUEUE_FULL),
              rsp.found && (rsp.queued_count == CNT_W'(ORDERS_PER_LEVEL)))

  // a stalled response word holds
  `ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall,
              rsp_valid && $stable(rsp))

endmodule

bind price_level_order_queue_table plq_checker u_plq_checker (.*);

// ===== tb/tb_price_level_order_queue_table.sv =====
// testbench for the price level order queue table against a behavioral book
module tb_price_level_order_queue_table;
  import plq_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int POOL_SIZE    = 80;
  localparam int LONG_HOLD    = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  req_t feed[$];
  rsp_t expected_replies[$];
  rsp_t want;
  int   feed_total = 0;
  int   taken = 0;
  int   errors = 0;
  bit   draining = 1'b0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;

  // behavioral book
  bit                    lvl_used[NUM_LEVELS];
  logic [PRICE_BITS-1:0] lvl_key[NUM_LEVELS];
  logic [HEAD_W-1:0]     lvl_first[NUM_LEVELS];
  logic [CNT_W-1:0]      lvl_depth[NUM_LEVELS];
  logic [ORDER_BITS-1:0] book[NUM_LEVELS][ORDERS_PER_LEVEL];
  logic [PRICE_BITS-1:0] tick_pool[POOL_SIZE];

  price_level_order_queue_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic rsp_t book_apply(req_t r);
    rsp_t res;
    int   hit;
    int   spare;
    int   slot;
    int   i;
    hit   = -1;
    spare = -1;
    res   = '0;
    for (i = 0; i < NUM_LEVELS; i++) begin
      if (lvl_used[i] && lvl_key[i] == r.price && hit < 0) hit = i;
      if (!lvl_used[i] && spare < 0) spare = i;
    end
    res.status = ST_OK;
    res.found  = (hit >= 0);
    case (r.req_type)
      REQ_INSERT: begin
        if (hit >= 0) begin
          if (int'(lvl_depth[hit]) >= ORDERS_PER_LEVEL) begin
            res.status = ST_QUEUE_FULL;
          end else begin
            slot = (int'(lvl_first[hit]) + int'(lvl_depth[hit])) % ORDERS_PER_LEVEL;
            book[hit][slot] = r.order_data;
            lvl_depth[hit] = lvl_depth[hit] + CNT_W'(1);
          end
          res.queued_count = lvl_depth[hit];
        end else if (spare < 0) begin
          res.status = ST_TABLE_FULL;
        end else begin
          lvl_used[spare]  = 1'b1;
          lvl_key[spare]   = r.price;
          lvl_first[spare] = '0;
          lvl_depth[spare] = CNT_W'(1);
          book[spare][0]   = r.order_data;
          res.queued_count = CNT_W'(1);
        end
      end
      REQ_REMOVE: begin
        if (hit >= 0) begin
          lvl_used[hit]  = 1'b0;
          lvl_first[hit] = '0;
          lvl_depth[hit] = '0;
        end else begin
          res.status = ST_MISS;
        end
      end
      REQ_POP: begin
        if (hit >= 0 && lvl_depth[hit] != 0) begin
          res.order_out    = book[hit][lvl_first[hit]];
          lvl_first[hit]   = HEAD_W'((int'(lvl_first[hit]) + 1) % ORDERS_PER_LEVEL);
          lvl_depth[hit]   = lvl_depth[hit] - CNT_W'(1);
          res.queued_count = lvl_depth[hit];
        end else begin
          res.status = ST_MISS;
        end
      end
      default: begin
        if (hit >= 0) res.queued_count = lvl_depth[hit];
        else res.status = ST_MISS;
      end
    endcase
    return res;
  endfunction

  function automatic int phase_now();
    int ph;
    if (feed_total == 0) return 0;
    ph = taken * 3 / feed_total;
    return (ph > 2) ? 2 : ph;
  endfunction

  task automatic push_req(input logic [1:0] kind, input logic [PRICE_BITS-1:0] p,
                          input logic [ORDER_BITS-1:0] d);
    req_t w;
    w.req_type   = kind;
    w.price      = p;
    w.order_data = d;
    feed.push_back(w);
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        expected_replies.push_back(book_apply(req));
        taken++;
        if (taken == feed_total / 2) draining = 1'b1;
      end
      if (draining && expected_replies.size() == 0) draining = 1'b0;
      if (!(req_valid && req_stall)) begin
        if (!draining && feed.size() != 0 &&
            $urandom_range(99) >= (phase_now() == 0 ? 8 : phase_now() == 1 ? 82 : 0)) begin
          req       <= feed.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("reply word with nothing expected");
        end else begin
          want = expected_replies.pop_front();
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", rsp.status, want.status));
          if (rsp.found !== want.found)
            report_mismatch($sformatf("found got %0d want %0d", rsp.found, want.found));
          if (rsp.order_out !== want.order_out)
            report_mismatch($sformatf("order_out got %h want %h",
                                      rsp.order_out, want.order_out));
          if (rsp.queued_count !== want.queued_count)
            report_mismatch($sformatf("queued_count got %0d want %0d",
                                      rsp.queued_count, want.queued_count));
        end
      end
      if (!hold_done && phase_now() == 2 && taken >= feed_total * 5 / 6) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < (phase_now() == 0 ? 82 : phase_now() == 1 ? 8 : 0));
      end
    end
  end

  initial begin
    #2000000;
    $display("tb_price_level_order_queue_table: FAIL");
    $finish;
  end

  initial begin
    int                    seq;
    int                    pick;
    int                    n;
    int                    p_base;
    int                    p_span;
    int                    j;
    int                    k;
    logic [PRICE_BITS-1:0] p;
    bit                    clash;

    tick_pool[0] = '0;
    tick_pool[1] = '1;
    for (j = 2; j < POOL_SIZE; j++) begin
      do begin
        p = PRICE_BITS'($urandom());
        clash = 1'b0;
        for (k = 0; k < j; k++) if (tick_pool[k] == p) clash = 1'b1;
      end while (clash);
      tick_pool[j] = p;
    end

    // directed: empty table, extreme prices and words, empty and missing levels
    push_req(REQ_SEARCH, '0, '0);
    push_req(REQ_POP,    '0, '1);
    push_req(REQ_REMOVE, '1, '0);
    push_req(REQ_INSERT, '0, '0);
    push_req(REQ_INSERT, '1, '1);
    push_req(REQ_INSERT, '0, 32'hA5A5_A5A5);
    push_req(REQ_SEARCH, '0, '0);
    push_req(REQ_SEARCH, '1, '0);
    push_req(REQ_POP,    '1, '0);
    push_req(REQ_POP,    '1, '0);
    push_req(REQ_SEARCH, '1, '0);
    push_req(REQ_INSERT, '1, 32'h5A5A_5A5A);
    push_req(REQ_REMOVE, '1, '0);
    push_req(REQ_SEARCH, '1, '0);
    push_req(REQ_POP,    '1, '0);
    push_req(REQ_POP,    '0, '0);
    push_req(REQ_POP,    '0, '0);
    push_req(REQ_POP,    '0, '0);
    push_req(REQ_REMOVE, '0, '0);
    push_req(REQ_REMOVE, '0, '0);

    seq = 0;
    while (feed.size() < 20 + RANDOM_ITEMS) begin
      pick = (seq == 0) ? 60 : (seq == 1) ? 72 : $urandom_range(99);
      if (pick < 55) begin
        // trading on a few neighboring levels
        p_span = $urandom_range(1, 6);
        p_base = $urandom_range(0, POOL_SIZE - p_span);
        n = $urandom_range(8, 30);
        for (j = 0; j < n; j++) begin
          k = $urandom_range(99);
          push_req(k < 45 ? REQ_INSERT : k < 75 ? REQ_POP : k < 90 ? REQ_SEARCH : REQ_REMOVE,
                   tick_pool[p_base + $urandom_range(0, p_span - 1)], $urandom());
        end
      end else if (pick < 70) begin
        // one deep level: queue full, then head wrap
        p = tick_pool[$urandom_range(2, POOL_SIZE - 1)];
        n = (seq == 0) ? 18 : $urandom_range(14, 20);
        for (j = 0; j < n; j++) push_req(REQ_INSERT, p, $urandom());
        n = $urandom_range(4, 16);
        for (j = 0; j < n; j++) push_req(REQ_POP, p, $urandom());
        n = $urandom_range(4, 12);
        for (j = 0; j < n; j++) push_req(REQ_INSERT, p, $urandom());
        push_req(REQ_SEARCH, p, $urandom());
        n = $urandom_range(0, 18);
        for (j = 0; j < n; j++) push_req(REQ_POP, p, $urandom());
        if ($urandom_range(1)) push_req(REQ_REMOVE, p, $urandom());
      end else if (pick < 73) begin
        // fill the table past full, then clear the pool prices
        k = $urandom_range(0, POOL_SIZE - 1);
        for (j = 0; j < NUM_LEVELS + 2; j++)
          push_req(REQ_INSERT, tick_pool[(k + j) % POOL_SIZE], $urandom());
        for (j = 0; j < 4; j++)
          push_req((j % 2) ? REQ_SEARCH : REQ_POP,
                   tick_pool[(k + $urandom_range(0, NUM_LEVELS + 1)) % POOL_SIZE], $urandom());
        for (j = 0; j < POOL_SIZE; j++) push_req(REQ_REMOVE, tick_pool[j], $urandom());
      end else if (pick < 88) begin
        // noise
        n = $urandom_range(3, 10);
        for (j = 0; j < n; j++)
          push_req(2'($urandom_range(0, 3)),
                   $urandom_range(1) ? PRICE_BITS'($urandom()) :
                                       tick_pool[$urandom_range(0, POOL_SIZE - 1)],
                   $urandom());
      end else begin
        // broken sequence around a removed level
        p = tick_pool[$urandom_range(0, POOL_SIZE - 1)];
        push_req(REQ_REMOVE, p, $urandom());
        push_req(REQ_POP,    p, $urandom());
        push_req(REQ_SEARCH, p, $urandom());
        push_req(REQ_INSERT, p, $urandom());
        push_req(REQ_POP,    p, $urandom());
        push_req(REQ_POP,    p, $urandom());
        push_req(REQ_REMOVE, p, $urandom());
      end
      seq++;
    end
    feed_total = feed.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (feed.size() != 0 || req_valid || expected_replies.size() != 0) @(posedge clk);
    repeat (NUM_LEVELS + 16) @(posedge clk);
    if (errors == 0) begin
      $display("tb_price_level_order_queue_table: PASS");
    end else begin
      $display("tb_price_level_order_queue_table: FAIL");
    end
    $finish;
  end

endmodule
